// ===== rtl/lfsa_pkg.sv =====
`default_nettype none
package lfsa_pkg;

    // build defaults
    localparam int SEATS_DEF     = 64;
    localparam int TIME_BITS_DEF = 20;

    // fixed field widths
    localparam int ID_W   = 6;
    localparam int SOUT_W = 6;
    localparam int STAT_W = 2;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ORDER = 2'd2;

endpackage
`default_nettype wire

// ===== rtl/lfsa_cell.sv =====
`default_nettype none
module lfsa_cell #(
    parameter int SEAT_W    = 6,
    parameter int TIME_BITS = lfsa_pkg::TIME_BITS_DEF,
    parameter int IDX       = 0
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 tok_in,
    input  wire logic                 found_in,
    input  wire logic [SEAT_W-1:0]    seat_in,
    input  wire logic                 first,
    input  wire logic [TIME_BITS-1:0] arrive,
    input  wire logic [TIME_BITS-1:0] leave,
    output logic                      tok_out,
    output logic                      found_out,
    output logic [SEAT_W-1:0]         seat_out
);

    logic                 busy_reg;
    logic [TIME_BITS-1:0] leave_reg;
    logic                 tok_reg;
    logic                 found_reg;
    logic [SEAT_W-1:0]    seat_reg;
    logic                 busy_eff;
    logic                 take;

    // release first, then claim if the token is still unserved
    assign busy_eff = first ? 1'b0 : (busy_reg && !(leave_reg <= arrive));
    assign take     = tok_in && !found_in && !busy_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            tok_reg   <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (tok_in)
            begin
                busy_reg <= busy_eff | take;
            end
            tok_reg   <= tok_in;
            found_reg <= found_in | take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            leave_reg <= leave;
        end
        seat_reg <= take ? SEAT_W'(IDX) : seat_in;
    end

    assign tok_out   = tok_reg;
    assign found_out = found_reg;
    assign seat_out  = seat_reg;

endmodule
`default_nettype wire

// ===== rtl/lowest_free_seat_allocator.sv =====
// Lowest free seat allocator.
// Input channel (in_valid / in_stall): one guest per transaction with
// arrive_time, leave_time, guest_id and first_guest. Arrivals are expected
// in nondecreasing order; an earlier non-first arrival is rejected, status 2.
// Output channel (out_valid / out_stall): one result per guest with the
// seat, an is_target flag (guest_id == target register) and a status
// (0 ok, 1 no free seat, 2 out of order). Rejected guests change nothing.
// cfg_we / cfg_data write the target guest register; write only when idle.
// A launch register starts a scan token that walks the seat chain one cell
// per cycle into the result register; an out-of-order guest skips the scan.
// One guest is in flight at a time: in_stall is high from acceptance until
// its result is loaded into the output register.
// Each seat cell releases itself when the token passes (first_guest frees
// all) and claims the guest if it is the first free cell.
// Reset clears every seat, the last arrival and the target register.
// A stalled result stays in the output register; the next result waits
// in the controller until the output register is free.
`default_nettype none
module lowest_free_seat_allocator #(
    parameter int SEATS     = lfsa_pkg::SEATS_DEF,
    parameter int TIME_BITS = lfsa_pkg::TIME_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // input channel
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [TIME_BITS-1:0]        arrive_time,
    input  wire logic [TIME_BITS-1:0]        leave_time,
    input  wire logic [lfsa_pkg::ID_W-1:0]   guest_id,
    input  wire logic                        first_guest,
    // output channel
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [lfsa_pkg::SOUT_W-1:0]      seat,
    output logic                             is_target,
    output logic [lfsa_pkg::STAT_W-1:0]      status,
    // configuration
    input  wire logic                        cfg_we,
    input  wire logic [lfsa_pkg::ID_W-1:0]   cfg_data
);

    localparam int SEAT_W = (SEATS > 1) ? $clog2(SEATS) : 1;

    // controller states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                     state_reg, state_next;
    logic [lfsa_pkg::ID_W-1:0]      target_reg;
    logic [TIME_BITS-1:0]           last_arr_reg;

    // current guest, broadcast to every cell during the scan
    logic [TIME_BITS-1:0]           arr_reg;
    logic [TIME_BITS-1:0]           lv_reg;
    logic                           first_reg;
    logic                           launch_reg;

    // pending result
    logic [lfsa_pkg::SOUT_W-1:0]    res_seat_reg;
    logic                           res_tgt_reg;
    logic [lfsa_pkg::STAT_W-1:0]    res_stat_reg;

    // output register
    logic                           out_valid_reg;
    logic [lfsa_pkg::SOUT_W-1:0]    out_seat_reg;
    logic                           out_tgt_reg;
    logic [lfsa_pkg::STAT_W-1:0]    out_stat_reg;

    // token chain taps: index 0 feeds the first cell, SEATS leaves the last
    logic                           tok_c   [SEATS+1];
    logic                           found_c [SEATS+1];
    logic [SEAT_W-1:0]              seat_c  [SEATS+1];

    logic                           accept;
    logic                           in_order;
    logic                           scan_end;
    logic                           load;
    logic [SEAT_W+lfsa_pkg::SOUT_W-1:0] seat_wide;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign in_order = first_guest || !(arrive_time < last_arr_reg);
    assign scan_end = tok_c[SEATS];
    assign load     = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // seat index zero-extended or truncated to the output width
    assign seat_wide = {{lfsa_pkg::SOUT_W{1'b0}}, seat_c[SEATS]};

    assign tok_c[0]   = launch_reg;
    assign found_c[0] = 1'b0;
    assign seat_c[0]  = '0;

    for (genvar g = 0; g < SEATS; g++)
    begin : g_cell
        lfsa_cell #(
            .SEAT_W    (SEAT_W),
            .TIME_BITS (TIME_BITS),
            .IDX       (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .tok_in    (tok_c[g]),
            .found_in  (found_c[g]),
            .seat_in   (seat_c[g]),
            .first     (first_reg),
            .arrive    (arr_reg),
            .leave     (lv_reg),
            .tok_out   (tok_c[g+1]),
            .found_out (found_c[g+1]),
            .seat_out  (seat_c[g+1])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = in_order ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            target_reg    <= '0;
            last_arr_reg  <= '0;
            launch_reg    <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= accept && in_order;
            if (cfg_we)
            begin
                target_reg <= cfg_data;
            end
            if (accept)
            begin
                first_reg <= first_guest;
            end
            // arrival is committed only when a seat was granted
            if (scan_end && found_c[SEATS])
            begin
                last_arr_reg <= arr_reg;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            arr_reg      <= arrive_time;
            lv_reg       <= leave_time;
            res_tgt_reg  <= (guest_id == target_reg);
            res_seat_reg <= '0;
            res_stat_reg <= lfsa_pkg::STAT_ORDER;
        end
        else if (scan_end)
        begin
            if (found_c[SEATS])
            begin
                res_seat_reg <= seat_wide[lfsa_pkg::SOUT_W-1:0];
                res_stat_reg <= lfsa_pkg::STAT_OK;
            end
            else
            begin
                res_seat_reg <= '0;
                res_stat_reg <= lfsa_pkg::STAT_FULL;
            end
        end
        if (load)
        begin
            out_seat_reg <= res_seat_reg;
            out_tgt_reg  <= res_tgt_reg;
            out_stat_reg <= res_stat_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign seat      = out_seat_reg;
    assign is_target = out_tgt_reg;
    assign status    = out_stat_reg;

endmodule
`default_nettype wire

// ===== dv/tb_lowest_free_seat_allocator.sv =====
`default_nettype none
module tb_lowest_free_seat_allocator;

    localparam int SEATS = lfsa_pkg::SEATS_DEF;
    localparam int TW    = lfsa_pkg::TIME_BITS_DEF;
    localparam logic [TW-1:0] TMAX = '1;
    localparam logic [lfsa_pkg::ID_W-1:0] ID_MAX = '1;

    // one expected grant per accepted guest
    typedef struct packed {
        logic [lfsa_pkg::SOUT_W-1:0] seat;
        logic                        is_target;
        logic [lfsa_pkg::STAT_W-1:0] status;
    } seat_grant_t;

    // receiver back-pressure styles
    typedef enum int {
        STALL_NONE,
        STALL_SPARSE,
        STALL_HEAVY
    } stall_mode_e;

    // arrival / duration shapes for a well-formed run of guests
    typedef enum int {
        DAY_CROWDED,
        DAY_SPREAD,
        DAY_MIXED,
        DAY_EARLY_LEAVE
    } day_shape_e;

    logic clk;
    logic rst_n = 1'b0;

    // all block inputs start at known values
    logic                        in_valid    = 1'b0;
    logic [TW-1:0]               arrive_time = '0;
    logic [TW-1:0]               leave_time  = '0;
    logic [lfsa_pkg::ID_W-1:0]   guest_id    = '0;
    logic                        first_guest = 1'b0;
    logic                        out_stall   = 1'b0;
    logic                        cfg_we      = 1'b0;
    logic [lfsa_pkg::ID_W-1:0]   cfg_data    = '0;

    logic                        in_stall;
    logic                        out_valid;
    logic [lfsa_pkg::SOUT_W-1:0] seat;
    logic                        is_target;
    logic [lfsa_pkg::STAT_W-1:0] status;

    lowest_free_seat_allocator #(
        .SEATS     (SEATS),
        .TIME_BITS (TW)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .arrive_time (arrive_time),
        .leave_time  (leave_time),
        .guest_id    (guest_id),
        .first_guest (first_guest),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .seat        (seat),
        .is_target   (is_target),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data)
    );

    // ------------------------------------------------------------------
    // Seat occupancy mirror. Updated at the edge a guest transaction is
    // accepted, so the grant queue stays in acceptance order.
    // ------------------------------------------------------------------
    logic [SEATS-1:0]          seat_taken;
    logic [TW-1:0]             seat_free_at [SEATS];
    logic [TW-1:0]             last_admit_time;
    logic [lfsa_pkg::ID_W-1:0] target_id;

    seat_grant_t grant_q [$];

    int guests_sent;
    int results_seen;
    int mismatch_count;
    int ok_count;
    int full_count;
    int order_count;
    int target_hits;
    int targets_written;

    // sender burst control
    int  burst_left;
    bit  gaps_enabled;

    // receiver stall control
    stall_mode_e stall_mode;
    int          stall_run;
    logic        stall_level;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop at roughly four times the slowest legal run: about 2k guests,
    // each with a full seat scan, the longest stall and the longest gap.
    initial
    begin
        #25_000_000;
        $display("tb: failure");
        $finish;
    end

    // Lowest free seat after releasing every seat whose leave time is at or
    // before this arrival. Order check first, except for a first guest,
    // which clears the room. A rejected guest leaves the mirror untouched.
    function automatic seat_grant_t allot_seat(
        input logic [TW-1:0]             arrive,
        input logic [TW-1:0]             leave,
        input logic [lfsa_pkg::ID_W-1:0] id,
        input logic                      first
    );
        seat_grant_t      g;
        logic [SEATS-1:0] still_taken;
        int               pick;
        g.seat      = '0;
        g.is_target = (id == target_id);
        g.status    = lfsa_pkg::STAT_OK;
        if (!first && arrive < last_admit_time)
        begin
            g.status = lfsa_pkg::STAT_ORDER;
            return g;
        end
        pick = -1;
        for (int s = 0; s < SEATS; s++)
        begin
            still_taken[s] = first ? 1'b0
                                   : (seat_taken[s] && !(seat_free_at[s] <= arrive));
            if (pick < 0 && !still_taken[s])
                pick = s;
        end
        if (pick < 0)
        begin
            g.status = lfsa_pkg::STAT_FULL;
            return g;
        end
        seat_taken         = still_taken;
        seat_taken[pick]   = 1'b1;
        seat_free_at[pick] = leave;
        last_admit_time    = arrive;
        g.seat             = pick[lfsa_pkg::SOUT_W-1:0];
        return g;
    endfunction

    // saturating time advance so a run of guests never wraps backwards
    function automatic logic [TW-1:0] later_time(input logic [TW-1:0] base,
                                                 input int unsigned inc);
        logic [TW:0] sum;
        sum = {1'b0, base} + inc[TW:0];
        return sum[TW] ? TMAX : sum[TW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Receiver: out_stall driven at the edge, pattern set per test phase.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        case (stall_mode)
            STALL_NONE:   out_stall <= 1'b0;
            STALL_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
            default:
            begin
                // alternating stalled and open runs of random length; open runs can last longer
                if (stall_run == 0)
                begin
                    stall_level = ~stall_level;
                    stall_run   = stall_level ? $urandom_range(1, 24) : $urandom_range(1, 40);
                end
                else
                    stall_run--;
                out_stall <= stall_level;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Result checker. Values read at the edge are pre-edge values, so an
    // output transaction is exactly out_valid && !out_stall here.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        seat_grant_t want;
        seat_grant_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.seat      = seat;
            got.is_target = is_target;
            got.status    = status;
            results_seen++;
            if (got.is_target === 1'b1)
                target_hits++;
            case (got.status)
                lfsa_pkg::STAT_OK:    ok_count++;
                lfsa_pkg::STAT_FULL:  full_count++;
                lfsa_pkg::STAT_ORDER: order_count++;
                default: ;
            endcase
            if (grant_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with nothing pending: seat=%0d is_target=%0b %s%0d",
                             $realtime, got.seat, got.is_target, "status=", got.status);
            end
            else
            begin
                want = grant_q.pop_front();
                if (got.seat !== want.seat || got.is_target !== want.is_target
                    || got.status !== want.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: mismatch seat exp=%0d got=%0d, %s%0b got=%0b, %s%0d got=%0d",
                                 $realtime, want.seat, got.seat,
                                 "is_target exp=", want.is_target, got.is_target,
                                 "status exp=", want.status, got.status);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender. Payload and valid change only right after an edge. Valid is
    // left high on return so back-to-back guests never drop it.
    // ------------------------------------------------------------------
    task automatic send_guest(
        input logic [TW-1:0]             arrive,
        input logic [TW-1:0]             leave,
        input logic [lfsa_pkg::ID_W-1:0] id,
        input logic                      first
    );
        seat_grant_t exp_grant;
        in_valid    <= 1'b1;
        arrive_time <= arrive;
        leave_time  <= leave;
        guest_id    <= id;
        first_guest <= first;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        // transaction taken at this edge
        exp_grant = allot_seat(arrive, leave, id, first);
        grant_q.insert(grant_q.size(), exp_grant);
        guests_sent++;
    endtask

    // Burst wrapper: after a random-length burst, drop valid for a random gap
    // with junk on the payload when gaps are enabled. Long gaps are rare but
    // land anywhere inside the seat scan.
    task automatic offer_guest(
        input logic [TW-1:0]             arrive,
        input logic [TW-1:0]             leave,
        input logic [lfsa_pkg::ID_W-1:0] id,
        input logic                      first
    );
        int gap;
        send_guest(arrive, leave, id, first);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 16);
            if (gaps_enabled)
            begin
                gap = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 70)
                                                   : $urandom_range(1, 12);
                in_valid    <= 1'b0;
                arrive_time <= TW'($urandom);
                leave_time  <= TW'($urandom);
                guest_id    <= lfsa_pkg::ID_W'($urandom);
                first_guest <= 1'($urandom);
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stop sending and wait for every pending grant. One result per guest,
    // so an empty queue means the block is idle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (grant_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_target(input logic [lfsa_pkg::ID_W-1:0] id);
        drain_results();
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= id;
        @(posedge clk);
        cfg_we    <= 1'b0;
        target_id  = id;
        targets_written++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, order violation, first-guest reset below the last
    // arrival, and a guest whose leave time is not after arrival.
    task automatic test_directed_cases();
        set_target(ID_MAX);
        stall_mode   = STALL_SPARSE;
        gaps_enabled = 1'b1;
        offer_guest('0, '0, '0, 1'b0);                       // no first guest after reset
        offer_guest('0, 20'd5, ID_MAX, 1'b0);                // previous seat leaves at arrival
        offer_guest(20'd3, TMAX, 6'd21, 1'b0);
        offer_guest(20'd2, 20'd7, ID_MAX, 1'b0);             // earlier than last: rejected
        offer_guest(20'd5, 20'd9, 6'h2A, 1'b0);
        offer_guest(TMAX, TMAX, 6'h15, 1'b0);                // frees everything
        offer_guest(TMAX, '0, ID_MAX, 1'b0);                 // leave before arrival
        offer_guest(TMAX, TMAX, 6'd1, 1'b0);
        offer_guest(20'd10, 20'd100, 6'd62, 1'b1);           // first guest below last arrival
        offer_guest(20'd10, 20'd20, '0, 1'b0);
        offer_guest(20'd9, 20'd50, 6'd7, 1'b0);              // rejected
        offer_guest('0, '0, ID_MAX, 1'b1);
        offer_guest(20'h55555, 20'hAAAAA, 6'h2A, 1'b0);
        offer_guest(20'hAAAAA, 20'h55555, 6'h15, 1'b0);
        offer_guest(20'hAAAAA, 20'hFFFFE, ID_MAX, 1'b1);
        offer_guest(20'hAAAAA, 20'hAAAAA, 6'h30, 1'b0);      // leave equals arrival
        offer_guest(20'hAAAAB, 20'h0000F, 6'h0F, 1'b0);
        offer_guest(TMAX, '0, '0, 1'b1);
        offer_guest(20'h00001, TMAX, '0, 1'b0);              // rejected, first not set
    endtask

    // Fill all seats with staggered leave times, hit the full case, check
    // that order rejection wins over full, then release partially and fully.
    task automatic test_seat_exhaustion();
        set_target('0);
        stall_mode   = STALL_HEAVY;
        gaps_enabled = 1'b1;
        for (int k = 0; k < SEATS; k++)
            offer_guest(20'd1000, TW'(5000 - 10 * k), lfsa_pkg::ID_W'(k), k == 0);
        offer_guest(20'd4000, 20'd9000, 6'd11, 1'b0);        // room full
        offer_guest(20'd999, 20'd9000, 6'd12, 1'b0);         // out of order while full
        offer_guest(20'd4500, 20'd9000, '0, 1'b0);           // upper seats free, lowest wins
        offer_guest(20'd4500, 20'd9000, 6'd13, 1'b0);
        offer_guest(20'd4500, 20'd9000, 6'd14, 1'b0);
        offer_guest(TMAX, TMAX, 6'd15, 1'b0);                // everyone leaves
    endtask

    // One well-formed run of guests starting with a first guest. Shape
    // controls how crowded the room gets.
    task automatic run_day(input day_shape_e shape, input int day_len);
        logic [TW-1:0]             arr;
        logic [TW-1:0]             lv;
        logic [lfsa_pkg::ID_W-1:0] id;
        logic                      first;
        int                        inc_max;
        int                        dur_lo;
        int                        dur_hi;
        case (shape)
            DAY_CROWDED:
            begin
                inc_max = 2;   dur_lo = 100; dur_hi = 3000;
            end
            DAY_SPREAD:
            begin
                inc_max = 400; dur_lo = 0;   dur_hi = 600;
            end
            DAY_MIXED:
            begin
                inc_max = 20;  dur_lo = 0;   dur_hi = 400;
            end
            default:
            begin
                inc_max = 50;  dur_lo = 0;   dur_hi = 60;
            end
        endcase
        for (int k = 0; k < day_len; k++)
        begin
            if (k == 0)
            begin
                first = 1'b1;
                arr   = ($urandom_range(0, 3) == 0) ? TMAX - TW'($urandom_range(0, 5000))
                                                    : TW'($urandom);
            end
            else if ($urandom_range(0, 19) == 0 && last_admit_time != '0)
            begin
                // stray early arrival inside the day
                first = 1'b0;
                arr   = last_admit_time - TW'($urandom_range(1, last_admit_time));
            end
            else
            begin
                first = ($urandom_range(0, 39) == 0);
                arr   = later_time(last_admit_time, $urandom_range(0, inc_max));
            end
            if (shape == DAY_EARLY_LEAVE && $urandom_range(0, 2) == 0)
                lv = arr - TW'($urandom_range(0, 50));
            else
                lv = arr + TW'($urandom_range(dur_lo, dur_hi));
            id = ($urandom_range(0, 7) == 0) ? target_id : lfsa_pkg::ID_W'($urandom);
            offer_guest(arr, lv, id, first);
        end
    endtask

    // Phases of mostly well-formed days plus raw noise; target register,
    // stall style and sender gaps change between phases. Stops at the
    // given total of guests sent over the whole run.
    task automatic test_random_traffic(input int total);
        int phase;
        int phase_end;
        int noise_len;
        int day_len;
        phase = 0;
        while (guests_sent < total)
        begin
            phase++;
            set_target(lfsa_pkg::ID_W'($urandom));
            stall_mode   = stall_mode_e'(phase % 3);
            gaps_enabled = (phase % 4 != 3);
            phase_end    = guests_sent + 220;
            while (guests_sent < phase_end && guests_sent < total)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    noise_len = $urandom_range(1, 4);
                    if (noise_len > total - guests_sent)
                        noise_len = total - guests_sent;
                    repeat (noise_len)
                        offer_guest(TW'($urandom), TW'($urandom), lfsa_pkg::ID_W'($urandom),
                                    $urandom_range(0, 7) == 0);
                end
                else
                begin
                    day_len = $urandom_range(8, 120);
                    if (day_len > total - guests_sent)
                        day_len = total - guests_sent;
                    run_day(day_shape_e'($urandom_range(0, 3)), day_len);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial
    begin
        seat_taken      = '0;
        last_admit_time = '0;
        target_id       = '0;
        guests_sent     = 0;
        results_seen    = 0;
        mismatch_count  = 0;
        ok_count        = 0;
        full_count      = 0;
        order_count     = 0;
        target_hits     = 0;
        targets_written = 0;
        burst_left      = 1;
        gaps_enabled    = 1'b1;
        stall_mode      = STALL_NONE;
        stall_run       = 0;
        stall_level     = 1'b0;
        for (int s = 0; s < SEATS; s++)
            seat_free_at[s] = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_seat_exhaustion();
        test_random_traffic(1750);

        drain_results();
        repeat (SEATS + 8) @(posedge clk);

        $display("run covered %0d guest transactions and %0d results over %0d target settings",
                 guests_sent, results_seen, targets_written);
        $display("seated %0d, room full %0d, out of order %0d, target flagged %0d, mismatches %0d",
                 ok_count, full_count, order_count, target_hits, mismatch_count);
        if (mismatch_count == 0 && grant_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire
